FILE: src/sba_pkg.sv
// Shared types and constants for the sparse block admissibility block.
// Command and result payloads, action and configuration codes, default sizes.
// No dependencies.
package sba_pkg;

  localparam int MAX_DIM_DEF     = 1024;
  localparam int MAX_ENTRIES_DEF = 8192;

  localparam logic [1:0] ACT_LOAD_ROW = 2'd0;
  localparam logic [1:0] ACT_LOAD_COL = 2'd1;
  localparam logic [1:0] ACT_QUERY    = 2'd2;

  localparam logic CFG_MAX_RANK = 1'b0;
  localparam logic CFG_EST_MODE = 1'b1;

  localparam logic [10:0] MAX_RANK_RESET = 11'd32;
  localparam logic [13:0] EST_MAX        = 14'h3FFF;

  typedef struct packed {
    logic [1:0]  action;
    logic [12:0] load_addr;
    logic [13:0] load_value;
    logic [9:0]  row_start;
    logic [10:0] row_count;
    logic [9:0]  col_start;
    logic [10:0] col_count;
    logic        same_cluster;
  } cmd_t;

  typedef struct packed {
    logic        admissible;
    logic [13:0] rank_estimate;
    logic        range_error;
  } result_t;

endpackage

FILE: src/sba_csr_mem.sv
// Compressed-row storage: row pointer memory and column index memory.
// One write and one registered read port each, read-first.
// Depends on sba_pkg for the default sizes.
module sba_csr_mem
  import sba_pkg::*;
#(
  parameter int  MAX_DIM     = MAX_DIM_DEF,
  parameter int  MAX_ENTRIES = MAX_ENTRIES_DEF,
  localparam int DW  = $clog2(MAX_DIM),
  localparam int DCW = $clog2(MAX_DIM + 1),
  localparam int EW  = $clog2(MAX_ENTRIES),
  localparam int ECW = $clog2(MAX_ENTRIES + 1)
) (
  input  logic           clk,
  input  logic           rp_we,
  input  logic [DCW-1:0] rp_waddr,
  input  logic [ECW-1:0] rp_wdata,
  input  logic [DCW-1:0] rp_raddr,
  output logic [ECW-1:0] rp_rdata,
  input  logic           ci_we,
  input  logic [EW-1:0]  ci_waddr,
  input  logic [DW-1:0]  ci_wdata,
  input  logic [EW-1:0]  ci_raddr,
  output logic [DW-1:0]  ci_rdata
);

  logic [ECW-1:0] rp_mem [MAX_DIM+1];
  logic [DW-1:0]  ci_mem [MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (rp_we) begin
      rp_mem[rp_waddr] <= rp_wdata;
    end
    rp_rdata <= rp_mem[rp_raddr];
  end

  always_ff @(posedge clk) begin
    if (ci_we) begin
      ci_mem[ci_waddr] <= ci_wdata;
    end
    ci_rdata <= ci_mem[ci_raddr];
  end

endmodule

FILE: src/sba_seen_map.sv
// Column occupancy bitmap for the current query window.
// Single address port; a write and the registered read of the same entry share it.
// Depends on sba_pkg for the default size.
module sba_seen_map
  import sba_pkg::*;
#(
  parameter int  MAX_DIM = MAX_DIM_DEF,
  localparam int DW = $clog2(MAX_DIM)
) (
  input  logic          clk,
  input  logic [DW-1:0] addr,
  input  logic          we,
  input  logic          wdata,
  output logic          rdata
);

  logic map_mem [MAX_DIM];

  // The read returns the value held before any write in the same cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      map_mem[addr] <= wdata;
    end
    rdata <= map_mem[addr];
  end

endmodule

FILE: src/sba_walker.sv
// Query sequencer: walks the row window through the CSR memories, marks columns,
// sweeps and clears the column map, then forms the estimate and the bound test.
// Depends on sba_pkg for the command and result types.
module sba_walker
  import sba_pkg::*;
#(
  parameter int  MAX_DIM     = MAX_DIM_DEF,
  parameter int  MAX_ENTRIES = MAX_ENTRIES_DEF,
  localparam int DW  = $clog2(MAX_DIM),
  localparam int DCW = $clog2(MAX_DIM + 1),
  localparam int EW  = $clog2(MAX_ENTRIES),
  localparam int ECW = $clog2(MAX_ENTRIES + 1)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  cmd_t           cmd,
  output logic           busy,
  output logic           done,
  output result_t        result,
  input  logic [10:0]    max_rank,
  input  logic           estimate_mode,
  output logic [DCW-1:0] rp_raddr,
  input  logic [ECW-1:0] rp_rdata,
  output logic [EW-1:0]  ci_raddr,
  input  logic [DW-1:0]  ci_rdata,
  output logic [DW-1:0]  map_addr,
  output logic           map_we,
  output logic           map_wdata,
  input  logic           map_rdata
);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_PTR_A = 9'b000000100,
    S_PTR_B = 9'b000001000,
    S_WALK  = 9'b000010000,
    S_SWEEP = 9'b000100000,
    S_EST   = 9'b001000000,
    S_MUL   = 9'b010000000,
    S_CMP   = 9'b100000000
  } state_t;

  state_t         state;
  logic [DCW-1:0] row_addr;
  logic [DCW-1:0] rows_left;
  logic [ECW-1:0] k;
  logic [ECW-1:0] cur_end;
  logic           pend;
  logic           hit;
  logic [13:0]    entry_count;
  logic [DCW-1:0] nz_rows;
  logic [DCW-1:0] sw_addr;
  logic           sw_pend;
  logic [DCW-1:0] col_rank;
  logic [9:0]     cs_q;
  logic [10:0]    col_end_q;
  logic [10:0]    cc_q;
  logic [21:0]    p_q;
  logic [12:0]    d_q;
  logic [13:0]    est;
  logic [27:0]    prod;

  logic           query;
  logic           win_err;
  logic [11:0]    dim_sum;
  logic           below;
  logic           above;
  logic           in_win;
  logic           stop;
  logic           issue;
  logic           sw_more;
  logic [DW-1:0]  mark_addr;
  logic [14:0]    est_inc;
  logic [DCW-1:0] min_rank;

  assign busy  = (state != S_IDLE);
  assign query = start && !busy && (cmd.action == ACT_QUERY);

  assign win_err = (32'(cmd.row_start) + 32'(cmd.row_count) > 32'(MAX_DIM)) ||
                   (32'(cmd.col_start) + 32'(cmd.col_count) > 32'(MAX_DIM));
  assign dim_sum = {1'b0, cmd.row_count} + {1'b0, cmd.col_count};

  // Entry walk: one column index read in flight, judged the cycle after issue.
  assign below     = 32'(ci_rdata) < 32'(cs_q);
  assign above     = 32'(ci_rdata) >= 32'(col_end_q);
  assign in_win    = pend && !below && !above;
  assign stop      = pend && above;
  assign issue     = !stop && (k < cur_end) && (32'(k) < 32'(MAX_ENTRIES));
  assign mark_addr = DW'(32'(ci_rdata) - 32'(cs_q));
  assign sw_more   = 32'(sw_addr) < 32'(cc_q);

  assign rp_raddr = (state == S_IDLE) ? DCW'(cmd.row_start) : row_addr;
  assign ci_raddr = k[EW-1:0];

  assign est_inc  = {1'b0, est} + 15'd1;
  assign min_rank = (nz_rows < col_rank) ? nz_rows : col_rank;

  always_comb begin
    map_addr  = sw_addr[DW-1:0];
    map_we    = 1'b0;
    map_wdata = 1'b0;
    case (state)
      S_CLEAR: begin
        map_we = 1'b1;
      end
      S_SWEEP: begin
        map_we = sw_more;
      end
      S_WALK: begin
        map_addr  = mark_addr;
        map_we    = in_win;
        map_wdata = 1'b1;
      end
      default: begin
        map_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      done    <= 1'b0;
      sw_addr <= '0;
      sw_pend <= 1'b0;
      pend    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          if (sw_addr == DCW'(MAX_DIM - 1)) begin
            state <= S_IDLE;
          end
          sw_addr <= sw_addr + DCW'(1);
        end
        S_IDLE: begin
          if (query) begin
            if (win_err || cmd.same_cluster) begin
              done                 <= 1'b1;
              result.admissible    <= 1'b0;
              result.rank_estimate <= '0;
              result.range_error   <= win_err;
            end else begin
              row_addr    <= DCW'(32'(cmd.row_start) + 1);
              rows_left   <= DCW'(cmd.row_count);
              cs_q        <= cmd.col_start;
              col_end_q   <= {1'b0, cmd.col_start} + cmd.col_count;
              cc_q        <= cmd.col_count;
              p_q         <= 22'(cmd.row_count) * 22'(cmd.col_count);
              d_q         <= {dim_sum, 1'b0};
              entry_count <= '0;
              nz_rows     <= '0;
              col_rank    <= '0;
              sw_addr     <= '0;
              sw_pend     <= 1'b0;
              state       <= (cmd.row_count == '0) ? S_SWEEP : S_PTR_A;
            end
          end
        end
        S_PTR_A: begin
          k        <= rp_rdata;
          row_addr <= row_addr + DCW'(1);
          state    <= S_PTR_B;
        end
        S_PTR_B: begin
          cur_end <= rp_rdata;
          pend    <= 1'b0;
          hit     <= 1'b0;
          state   <= S_WALK;
        end
        S_WALK: begin
          if (in_win) begin
            hit <= 1'b1;
            if (entry_count != EST_MAX) begin
              entry_count <= entry_count + 14'd1;
            end
          end
          if (issue) begin
            k    <= k + ECW'(1);
            pend <= 1'b1;
          end else begin
            // Row finished: the next row starts where this one was meant to end.
            pend      <= 1'b0;
            nz_rows   <= nz_rows + DCW'(hit || in_win);
            rows_left <= rows_left - DCW'(1);
            if (rows_left == DCW'(1)) begin
              state <= S_SWEEP;
            end else begin
              k        <= cur_end;
              row_addr <= row_addr + DCW'(1);
              state    <= S_PTR_B;
            end
          end
        end
        S_SWEEP: begin
          if (sw_pend) begin
            col_rank <= col_rank + DCW'(map_rdata);
          end
          if (sw_more) begin
            sw_addr <= sw_addr + DCW'(1);
            sw_pend <= 1'b1;
          end else begin
            sw_pend <= 1'b0;
            if (!sw_pend) begin
              state <= S_EST;
            end
          end
        end
        S_EST: begin
          est   <= estimate_mode ? 14'(min_rank) : entry_count;
          state <= S_MUL;
        end
        S_MUL: begin
          // est < floor(P / D) holds exactly when (est + 1) * D <= P.
          prod  <= 28'(est_inc) * 28'(d_q);
          state <= S_CMP;
        end
        S_CMP: begin
          done                 <= 1'b1;
          result.admissible    <= (d_q != '0) && (prod <= 28'(p_q)) &&
                                  (est <= 14'(max_rank));
          result.rank_estimate <= est;
          result.range_error   <= 1'b0;
          state                <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/sparse_block_admissibility.sv
// Sparse block admissibility test. Loads give no result.
// A query with a window error or identical clusters answers on the next cycle.
// Otherwise the query reads the row window's column indices through the single read port
// of the column index memory, then sweeps the column map over col_count entries.
// Reset starts a column map clearing pass over all MAX_DIM entries with busy high.
// The done strobe is high for one cycle only; the receiver cannot stall.
module sparse_block_admissibility
  import sba_pkg::*;
#(
  parameter int MAX_DIM     = MAX_DIM_DEF,
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  cmd_t        cmd,
  output logic        busy,
  output logic        done,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data
);

  localparam int DW  = $clog2(MAX_DIM);
  localparam int DCW = $clog2(MAX_DIM + 1);
  localparam int EW  = $clog2(MAX_ENTRIES);
  localparam int ECW = $clog2(MAX_ENTRIES + 1);

  logic [10:0]    max_rank;
  logic           estimate_mode;
  logic           load_ok;
  logic           rp_we;
  logic           ci_we;
  logic [ECW-1:0] rp_wdata;
  logic [DCW-1:0] rp_raddr;
  logic [ECW-1:0] rp_rdata;
  logic [EW-1:0]  ci_raddr;
  logic [DW-1:0]  ci_rdata;
  logic [DW-1:0]  map_addr;
  logic           map_we;
  logic           map_wdata;
  logic           map_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_rank      <= MAX_RANK_RESET;
      estimate_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_RANK: max_rank <= cfg_data;
        CFG_EST_MODE: estimate_mode <= cfg_data[0];
        default: max_rank <= max_rank;
      endcase
    end
  end

  // Loads out of range are dropped; oversized row pointers are clamped.
  assign load_ok  = start && !busy;
  assign rp_we    = load_ok && (cmd.action == ACT_LOAD_ROW) &&
                    (32'(cmd.load_addr) <= 32'(MAX_DIM));
  assign ci_we    = load_ok && (cmd.action == ACT_LOAD_COL) &&
                    (32'(cmd.load_addr) < 32'(MAX_ENTRIES)) &&
                    (32'(cmd.load_value) < 32'(MAX_DIM));
  assign rp_wdata = (32'(cmd.load_value) > 32'(MAX_ENTRIES)) ?
                    ECW'(MAX_ENTRIES) : ECW'(cmd.load_value);

  sba_csr_mem #(
    .MAX_DIM     (MAX_DIM),
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_csr_mem (
    .clk      (clk),
    .rp_we    (rp_we),
    .rp_waddr (DCW'(cmd.load_addr)),
    .rp_wdata (rp_wdata),
    .rp_raddr (rp_raddr),
    .rp_rdata (rp_rdata),
    .ci_we    (ci_we),
    .ci_waddr (EW'(cmd.load_addr)),
    .ci_wdata (DW'(cmd.load_value)),
    .ci_raddr (ci_raddr),
    .ci_rdata (ci_rdata)
  );

  sba_seen_map #(
    .MAX_DIM (MAX_DIM)
  ) u_seen_map (
    .clk   (clk),
    .addr  (map_addr),
    .we    (map_we),
    .wdata (map_wdata),
    .rdata (map_rdata)
  );

  sba_walker #(
    .MAX_DIM     (MAX_DIM),
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_walker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .cmd           (cmd),
    .busy          (busy),
    .done          (done),
    .result        (result),
    .max_rank      (max_rank),
    .estimate_mode (estimate_mode),
    .rp_raddr      (rp_raddr),
    .rp_rdata      (rp_rdata),
    .ci_raddr      (ci_raddr),
    .ci_rdata      (ci_rdata),
    .map_addr      (map_addr),
    .map_we        (map_we),
    .map_wdata     (map_wdata),
    .map_rdata     (map_rdata)
  );

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for sparse_block_admissibility: a directed table, then random
// matrix builds, window queries and noise, scored by the table or an in-bench predictor.
// Depends on sba_pkg and the sparse_block_admissibility module.
module tb_top;
  import sba_pkg::*;

  localparam int DIM             = MAX_DIM_DEF;
  localparam int ENTRIES         = MAX_ENTRIES_DEF;
  localparam int CYCLE_LIMIT     = 12_000_000;
  localparam int DRAIN_CYCLES    = 2500;
  localparam int ITEMS_PER_PHASE = 340;
  localparam int MAX_REPORTS     = 40;

  localparam logic [1:0] ACT_SPARE = 2'd3;

  localparam result_t VERDICT_NONE  = '0;
  localparam result_t VERDICT_RANGE = '{admissible: 1'b0, rank_estimate: 14'd0,
                                        range_error: 1'b1};

  typedef struct packed {
    cmd_t    c;
    logic    typed;
    result_t want;
  } table_row_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        start     = 1'b0;
  cmd_t        cmd_bus   = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_index = CFG_MAX_RANK;
  logic [10:0] cfg_data  = '0;
  logic        busy;
  logic        done;
  logic        cfg_ready;
  result_t     result_bus;

  // Predictor state: the two stores, which entries hold data, and the registers.
  logic [13:0] ptr_model      [0:DIM];
  bit          ptr_written    [0:DIM];
  logic [9:0]  colidx_model   [0:ENTRIES-1];
  bit          colidx_written [0:ENTRIES-1];
  logic [10:0] rank_limit_model = MAX_RANK_RESET;
  logic        est_mode_model   = 1'b0;

  result_t    expected_verdicts [$];
  table_row_t directed_rows [$];
  result_t    verdict_due;

  int error_count     = 0;
  int cycle_count     = 0;
  int items_sent      = 0;
  int queries_sent    = 0;
  int results_seen    = 0;
  int admissible_seen = 0;
  int config_writes   = 0;
  int sender_idle_pct = 0;
  int last_row        = 0;
  int last_rows       = 0;
  int last_entry      = 0;
  int last_entries    = 0;

  sparse_block_admissibility u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd_bus),
    .busy      (busy),
    .done      (done),
    .result    (result_bus),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(string what);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic cmd_t random_cmd();
    logic [95:0] raw;
    cmd_t        c;
    raw = {$urandom, $urandom, $urandom};
    c = raw[$bits(cmd_t)-1:0];
    return c;
  endfunction

  function automatic cmd_t load_cmd(logic [1:0] act, int addr, int value);
    cmd_t c;
    c = random_cmd();
    c.action     = act;
    c.load_addr  = 13'(addr);
    c.load_value = 14'(value);
    return c;
  endfunction

  function automatic cmd_t query_cmd(int rs, int rc, int cs, int cc, bit same);
    cmd_t c;
    c = random_cmd();
    c.action       = ACT_QUERY;
    c.row_start    = 10'(rs);
    c.row_count    = 11'(rc);
    c.col_start    = 10'(cs);
    c.col_count    = 11'(cc);
    c.same_cluster = same;
    return c;
  endfunction

  function automatic void add_row(cmd_t c, logic typed, result_t want);
    table_row_t r;
    r.c     = c;
    r.typed = typed;
    r.want  = want;
    directed_rows.push_back(r);
  endfunction

  // Walks the row window of a query and works out the verdict the block should give.
  function automatic result_t predict_block_verdict(cmd_t c);
    result_t r;
    bit      col_hit [0:DIM-1];
    bit      row_hit;
    int      rs, rc, cs, cc, row, k, kend, j;
    int      nz_rows, nz_entries, col_rank, est, bound;
    rs = c.row_start;
    rc = c.row_count;
    cs = c.col_start;
    cc = c.col_count;
    r = VERDICT_NONE;
    if (rs + rc > DIM || cs + cc > DIM) return VERDICT_RANGE;
    if (c.same_cluster) return r;
    foreach (col_hit[i]) col_hit[i] = 1'b0;
    nz_rows    = 0;
    nz_entries = 0;
    col_rank   = 0;
    for (row = rs; row < rs + rc; row++) begin
      row_hit = 1'b0;
      kend = ptr_model[row + 1];
      for (k = ptr_model[row]; k < kend && k < ENTRIES; k++) begin
        j = colidx_model[k];
        if (j < cs) continue;
        // Columns ascend within a row, so the first one past the window ends the row.
        if (j >= cs + cc) break;
        if (nz_entries < EST_MAX) nz_entries++;
        row_hit = 1'b1;
        col_hit[j - cs] = 1'b1;
      end
      if (row_hit) nz_rows++;
    end
    for (j = 0; j < cc; j++) col_rank += col_hit[j];
    est = est_mode_model ? ((nz_rows < col_rank) ? nz_rows : col_rank) : nz_entries;
    bound = (rc + cc != 0) ? (rc * cc) / (2 * (rc + cc)) : 0;
    r.admissible    = (est < bound) && (est <= rank_limit_model);
    r.rank_estimate = 14'(est);
    return r;
  endfunction

  // True when the walk of this query touches only store entries that hold data.
  function automatic bit walk_is_defined(cmd_t c);
    int row, k, kend;
    if (c.action != ACT_QUERY || c.same_cluster) return 1'b1;
    if (int'(c.row_start) + int'(c.row_count) > DIM) return 1'b1;
    if (int'(c.col_start) + int'(c.col_count) > DIM) return 1'b1;
    for (row = c.row_start; row < int'(c.row_start) + int'(c.row_count); row++) begin
      if (!ptr_written[row] || !ptr_written[row + 1]) return 1'b0;
      kend = ptr_model[row + 1];
      for (k = ptr_model[row]; k < kend && k < ENTRIES; k++) begin
        if (!colidx_written[k]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic void commit_cmd(cmd_t c, logic typed, result_t want);
    if (c.action != ACT_SPARE) items_sent++;
    case (c.action)
      ACT_LOAD_ROW: begin
        if (c.load_addr <= DIM) begin
          ptr_model[c.load_addr]   = (c.load_value > ENTRIES) ? 14'(ENTRIES) : c.load_value;
          ptr_written[c.load_addr] = 1'b1;
        end
      end
      ACT_LOAD_COL: begin
        if (c.load_addr < ENTRIES && c.load_value < DIM) begin
          colidx_model[c.load_addr]   = c.load_value[9:0];
          colidx_written[c.load_addr] = 1'b1;
        end
      end
      ACT_QUERY: begin
        queries_sent++;
        expected_verdicts.push_back(typed ? want : predict_block_verdict(c));
      end
      default: ;
    endcase
  endfunction

  // Start stays high after a transfer so back-to-back commands need no new rise.
  task automatic issue_cmd(cmd_t c, logic typed, result_t want);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    cmd_bus <= c;
    do @(posedge clk); while (busy);
    commit_cmd(c, typed, want);
  endtask

  task automatic settle_block();
    start <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_config(logic [10:0] rank_limit, logic mode);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_MAX_RANK;
    cfg_data  <= rank_limit;
    do @(posedge clk); while (!cfg_ready);
    rank_limit_model = rank_limit;
    cfg_index <= CFG_EST_MODE;
    cfg_data  <= {10'($urandom), mode};
    do @(posedge clk); while (!cfg_ready);
    est_mode_model = mode;
    cfg_valid <= 1'b0;
    config_writes += 2;
  endtask

  task automatic retune();
    logic [10:0] limit;
    case ($urandom_range(3))
      0: limit = 11'd0;
      1: limit = 11'd1024;
      2: limit = 11'($urandom_range(0, 16));
      default: limit = 11'($urandom_range(0, 1024));
    endcase
    settle_block();
    write_config(limit, 1'($urandom_range(1)));
  endtask

  // Loads a well-formed band of rows in compressed-row form, then queries windows on it.
  task automatic build_and_probe();
    int   n, per_row, base_row, base_entry, col_base, col, cnt, i, pi, ci;
    int   rs, rc, cs, cc;
    int   row_ptrs [$];
    int   cols [$];
    bit   same;
    cmd_t c;
    if ($urandom_range(19) == 0) begin
      n = $urandom_range(25, 120);
      per_row = 2;
    end else begin
      n = $urandom_range(1, 24);
      per_row = 6;
    end
    base_row   = $urandom_range(0, DIM - n);
    base_entry = $urandom_range(0, ENTRIES - n * per_row);
    col_base   = $urandom_range(0, DIM - 1);
    for (i = 0; i < n; i++) begin
      row_ptrs.push_back(base_entry + cols.size());
      cnt = $urandom_range(0, per_row);
      col = col_base + $urandom_range(0, 15);
      while (cnt > 0 && col < DIM) begin
        cols.push_back(col);
        col += $urandom_range(1, 12);
        cnt--;
      end
    end
    row_ptrs.push_back(base_entry + cols.size());
    last_row     = base_row;
    last_rows    = n;
    last_entry   = base_entry;
    last_entries = cols.size();

    pi = 0;
    ci = 0;
    while (pi <= n || ci < cols.size()) begin
      if (ci >= cols.size() || (pi <= n && $urandom_range(1) == 0)) begin
        issue_cmd(load_cmd(ACT_LOAD_ROW, base_row + pi, row_ptrs[pi]), 1'b0, VERDICT_NONE);
        pi++;
      end else begin
        issue_cmd(load_cmd(ACT_LOAD_COL, base_entry + ci, cols[ci]), 1'b0, VERDICT_NONE);
        ci++;
      end
    end

    repeat ($urandom_range(2, 6)) begin
      rs = base_row + $urandom_range(0, n - 1);
      rc = $urandom_range(1, base_row + n - rs);
      cs = col_base - int'($urandom_range(0, 8));
      if (cs < 0) cs = 0;
      cc = $urandom_range(1, 64);
      if (cs + cc > DIM) cc = DIM - cs;
      same = 1'b0;
      case ($urandom_range(11))
        0: cc = $urandom_range(0, DIM - cs);
        1: begin
          cs = 0;
          cc = DIM;
        end
        2: same = 1'b1;
        3: rc = $urandom_range(DIM - rs + 1, 2047);
        4: cc = $urandom_range(DIM - cs + 1, 2047);
        5: begin
          if ($urandom_range(1)) rc = 0;
          else cc = 0;
        end
        6: begin
          rs = $urandom_range(0, DIM - 1);
          rc = $urandom_range(1, 64);
          if (rs + rc > DIM) rc = DIM - rs;
        end
        default: ;
      endcase
      c = query_cmd(rs, rc, cs, cc, same);
      if (walk_is_defined(c)) issue_cmd(c, 1'b0, VERDICT_NONE);
    end
  endtask

  // Random commands and corrupting loads aimed at the band most recently built.
  task automatic inject_noise();
    cmd_t c;
    case ($urandom_range(3))
      0: c = random_cmd();
      1: c = load_cmd(ACT_LOAD_ROW, last_row + $urandom_range(0, last_rows),
                      $urandom_range(0, ENTRIES + 64));
      2: c = load_cmd(ACT_LOAD_COL, last_entry + $urandom_range(0, last_entries),
                      $urandom_range(0, DIM - 1));
      default: begin
        c = random_cmd();
        c.action = ACT_QUERY;
      end
    endcase
    if (walk_is_defined(c)) issue_cmd(c, 1'b0, VERDICT_NONE);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      results_seen++;
      if (expected_verdicts.size() == 0) begin
        report_mismatch("result strobe with no query outstanding");
      end else begin
        verdict_due = expected_verdicts.pop_front();
        if (result_bus.admissible !== verdict_due.admissible)
          report_mismatch($sformatf("admissible %b, expected %b",
                                    result_bus.admissible, verdict_due.admissible));
        if (result_bus.rank_estimate !== verdict_due.rank_estimate)
          report_mismatch($sformatf("rank_estimate %0d, expected %0d",
                                    result_bus.rank_estimate, verdict_due.rank_estimate));
        if (result_bus.range_error !== verdict_due.range_error)
          report_mismatch($sformatf("range_error %b, expected %b",
                                    result_bus.range_error, verdict_due.range_error));
        if (verdict_due.admissible) admissible_seen++;
      end
    end
  end

  initial begin
    cmd_t ones;
    int   phase;
    int   phase_target;
    ones = '1;

    // Window checks and identical clusters first, while both stores are still empty.
    add_row(query_cmd(DIM - 1, 2, 0, 1, 1'b0), 1'b1, VERDICT_RANGE);
    add_row(query_cmd(0, 1, 1000, 25, 1'b0), 1'b1, VERDICT_RANGE);
    add_row(query_cmd(DIM - 1, 1024, DIM - 1, 1024, 1'b1), 1'b1, VERDICT_RANGE);
    add_row(query_cmd(0, DIM, 0, DIM, 1'b1), 1'b1, VERDICT_NONE);
    add_row(ones, 1'b0, VERDICT_NONE);
    add_row(load_cmd(ACT_LOAD_ROW, ENTRIES - 1, 16383), 1'b0, VERDICT_NONE);
    add_row(load_cmd(ACT_LOAD_ROW, DIM + 1, 5), 1'b0, VERDICT_NONE);
    add_row(load_cmd(ACT_LOAD_COL, ENTRIES - 1, DIM - 1), 1'b0, VERDICT_NONE);
    add_row(load_cmd(ACT_LOAD_COL, ENTRIES - 2, 16383), 1'b0, VERDICT_NONE);
    add_row(load_cmd(ACT_LOAD_COL, ENTRIES - 2, 0), 1'b0, VERDICT_NONE);
    add_row(load_cmd(ACT_LOAD_ROW, DIM - 1, ENTRIES - 2), 1'b0, VERDICT_NONE);
    add_row(load_cmd(ACT_LOAD_ROW, DIM, 16383), 1'b0, VERDICT_NONE);
    add_row(query_cmd(DIM - 1, 1, 0, DIM, 1'b0), 1'b0, VERDICT_NONE);
    // Row 1 is empty and row 2 has its end pointer below its start.
    add_row(load_cmd(ACT_LOAD_ROW, 0, 0), 1'b0, VERDICT_NONE);
    add_row(load_cmd(ACT_LOAD_ROW, 1, 3), 1'b0, VERDICT_NONE);
    add_row(load_cmd(ACT_LOAD_ROW, 2, 3), 1'b0, VERDICT_NONE);
    add_row(load_cmd(ACT_LOAD_ROW, 3, 1), 1'b0, VERDICT_NONE);
    add_row(load_cmd(ACT_LOAD_ROW, 4, 5), 1'b0, VERDICT_NONE);
    add_row(load_cmd(ACT_LOAD_COL, 0, 0), 1'b0, VERDICT_NONE);
    add_row(load_cmd(ACT_LOAD_COL, 1, 5), 1'b0, VERDICT_NONE);
    add_row(load_cmd(ACT_LOAD_COL, 2, 9), 1'b0, VERDICT_NONE);
    add_row(load_cmd(ACT_LOAD_COL, 3, 12), 1'b0, VERDICT_NONE);
    add_row(load_cmd(ACT_LOAD_COL, 4, DIM - 1), 1'b0, VERDICT_NONE);
    add_row(query_cmd(0, 4, 0, DIM, 1'b0), 1'b0, VERDICT_NONE);
    add_row(query_cmd(0, 0, 0, 10, 1'b0), 1'b1, VERDICT_NONE);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      issue_cmd(directed_rows[i].c, directed_rows[i].typed, directed_rows[i].want);

    for (phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 61 : 0;
      settle_block();
      case (phase)
        0: write_config(11'd0, 1'b1);
        1: write_config(11'd1024, 1'b0);
        default: write_config(11'($urandom_range(0, 1024)), 1'($urandom_range(1)));
      endcase
      phase_target = items_sent + ITEMS_PER_PHASE;
      while (items_sent < phase_target) begin
        if ($urandom_range(9) < 7) begin
          if ($urandom_range(3) == 0) retune();
          build_and_probe();
        end else begin
          inject_noise();
        end
      end
    end

    start <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d commands, %0d of them queries, across three pacing phases and %0d %s",
             items_sent, queries_sent, config_writes, "register writes.");
    $display("Scored %0d verdicts (%0d admissible); %0d mismatches.",
             results_seen, admissible_seen, error_count);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/sba_pkg.sv
src/sba_csr_mem.sv
src/sba_seen_map.sv
src/sba_walker.sv
src/sparse_block_admissibility.sv
verif/tb_top.sv
